// File: src/systematic_resampler_top_assert.svh
// Assertion macros for the systematic resampler checker.
// Used only by systematic_resampler_top_chk; expects clk_i and rst_ni in scope.
`ifndef SYSTEMATIC_RESAMPLER_TOP_ASSERT_SVH
`define SYSTEMATIC_RESAMPLER_TOP_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define SRS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("srs check failed");

// Consequent checked in the cycle after the antecedent.
`define SRS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("srs check failed");

`endif

// File: src/srs_pkg.sv
// Shared types and fixed field widths for the systematic resampler.
// No dependencies.
package srs_pkg;

  localparam int unsigned CfgW     = 4;
  localparam int unsigned CfgReset = 8;
  localparam int unsigned WeightW  = 25;
  localparam int unsigned OffsetW  = 23;
  localparam int unsigned CopiesW  = 9;
  localparam int unsigned IdxW     = 8;
  localparam int unsigned CumW     = 33;

  localparam logic [CumW-1:0] CumMax = {CumW{1'b1}};

  // Control that travels with one item from the accumulate stage to the spoke stage.
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } srs_ctrl_t;

endpackage

// File: src/systematic_resampler_top.sv
// Result registered in the accumulate stage and then the spoke stage (two register stages).
// Throughput: one item per cycle while the output is not stalled; the accumulate and
// spoke stages each keep their running state in one register. Each stage stalls only
// while its own register is held.
// Reset: asynchronous, active low; pipeline empty, set counter at particle 0,
// count_log2 = 8. Any count_log2 write restarts the set.
module systematic_resampler_top import srs_pkg::*; #(
  parameter int unsigned MAX_COUNT_LOG2 = 8,
  parameter int unsigned FRACTION_BITS  = 24
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgW-1:0]    cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [WeightW-1:0] weight_i,
  input  logic [OffsetW-1:0] offset_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [CopiesW-1:0] copies_o,
  output logic [IdxW-1:0]    particle_index_o,
  output logic               last_o
);

  localparam int unsigned NW  = MAX_COUNT_LOG2 + 1;
  localparam int unsigned IW  = MAX_COUNT_LOG2;
  localparam int unsigned LgW = $clog2(MAX_COUNT_LOG2 + 1);
  localparam int unsigned ShW = $clog2(FRACTION_BITS + 1);

  logic [CfgW-1:0]    cfg_q;
  logic [LgW-1:0]     lg;
  logic [ShW-1:0]     shift;
  logic [NW-1:0]      count;
  srs_ctrl_t          ctrl;
  logic               s2_ready;
  logic [CumW-1:0]    cum;
  logic [OffsetW-1:0] off;
  logic [IW-1:0]      idx;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgW'(CfgReset);
    end else if (cfg_we_i) begin
      cfg_q <= cfg_wdata_i;
    end
  end

  // clamp set size to the supported range
  always_comb begin
    if (cfg_q == '0) begin
      lg = LgW'(1);
    end else if (32'(cfg_q) > MAX_COUNT_LOG2) begin
      lg = LgW'(MAX_COUNT_LOG2);
    end else begin
      lg = LgW'(cfg_q);
    end
  end

  // spoke spacing is 2^shift; one LSB when the set outgrows the fraction
  assign shift = (32'(lg) >= FRACTION_BITS) ? '0 : ShW'(FRACTION_BITS - 32'(lg));
  assign count = NW'(1) << lg;

  srs_accum #(
    .MAX_COUNT_LOG2(MAX_COUNT_LOG2),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_accum (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .restart_i (cfg_we_i),
    .shift_i   (shift),
    .count_i   (count),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .weight_i  (weight_i),
    .offset_i  (offset_i),
    .ctrl_o    (ctrl),
    .ready_i   (s2_ready),
    .cum_o     (cum),
    .off_o     (off),
    .idx_o     (idx)
  );

  srs_spoke #(
    .MAX_COUNT_LOG2(MAX_COUNT_LOG2),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_spoke (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .shift_i         (shift),
    .count_i         (count),
    .ctrl_i          (ctrl),
    .ready_o         (s2_ready),
    .cum_i           (cum),
    .off_i           (off),
    .idx_i           (idx),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .copies_o        (copies_o),
    .particle_index_o(particle_index_o),
    .last_o          (last_o)
  );

endmodule

// File: src/srs_accum.sv
// Stage 1: running saturating cumulative weight, offset latch and particle counter.
// Depends on srs_pkg.
module srs_accum import srs_pkg::*; #(
  parameter int unsigned MAX_COUNT_LOG2 = 8,
  parameter int unsigned FRACTION_BITS  = 24,
  localparam int unsigned NW  = MAX_COUNT_LOG2 + 1,
  localparam int unsigned IW  = MAX_COUNT_LOG2,
  localparam int unsigned ShW = $clog2(FRACTION_BITS + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               restart_i,
  input  logic [ShW-1:0]     shift_i,
  input  logic [NW-1:0]      count_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [WeightW-1:0] weight_i,
  input  logic [OffsetW-1:0] offset_i,
  output srs_ctrl_t          ctrl_o,
  input  logic               ready_i,
  output logic [CumW-1:0]    cum_o,
  output logic [OffsetW-1:0] off_o,
  output logic [IW-1:0]      idx_o
);

  logic               valid_q, first_q, last_q;
  logic [IW-1:0]      cnt_q, cnt_d, idx_q;
  logic [CumW-1:0]    cum_q, cum_d;
  logic [OffsetW-1:0] off_q, off_d;
  logic               accept, first, last;
  logic [CumW:0]      sum;
  logic [31:0]        mask;

  assign in_ready_o = !valid_q || ready_i;
  assign accept     = in_valid_i && in_ready_o;

  assign first = (cnt_q == '0);
  assign last  = (32'(cnt_q) + 32'd1) >= 32'(count_i);

  // cum_q and off_q hold the previous item's values, which is the running state
  assign sum   = (first ? '0 : {1'b0, cum_q}) + (CumW + 1)'(weight_i);
  assign cum_d = sum[CumW] ? CumMax : sum[CumW-1:0];

  assign mask  = (32'd1 << shift_i) - 32'd1;
  assign off_d = first ? (offset_i & mask[OffsetW-1:0]) : off_q;

  always_comb begin
    cnt_d = cnt_q;
    if (restart_i) begin
      cnt_d = '0;
    end else if (accept) begin
      cnt_d = last ? '0 : cnt_q + IW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      cnt_q   <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (accept) begin
        valid_q <= 1'b1;
      end else if (ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cum_q   <= cum_d;
      off_q   <= off_d;
      idx_q   <= cnt_q;
      first_q <= first;
      last_q  <= last;
    end
  end

  assign ctrl_o = '{valid: valid_q, first: first_q, last: last_q};
  assign cum_o  = cum_q;
  assign off_o  = off_q;
  assign idx_o  = idx_q;

endmodule

// File: src/srs_spoke.sv
// Stage 2: spokes covered by the cumulative weight, copies per particle, result register.
// Depends on srs_pkg.
module srs_spoke import srs_pkg::*; #(
  parameter int unsigned MAX_COUNT_LOG2 = 8,
  parameter int unsigned FRACTION_BITS  = 24,
  localparam int unsigned NW  = MAX_COUNT_LOG2 + 1,
  localparam int unsigned IW  = MAX_COUNT_LOG2,
  localparam int unsigned ShW = $clog2(FRACTION_BITS + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [ShW-1:0]     shift_i,
  input  logic [NW-1:0]      count_i,
  input  srs_ctrl_t          ctrl_i,
  output logic               ready_o,
  input  logic [CumW-1:0]    cum_i,
  input  logic [OffsetW-1:0] off_i,
  input  logic [IW-1:0]      idx_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [CopiesW-1:0] copies_o,
  output logic [IdxW-1:0]    particle_index_o,
  output logic               last_o
);

  logic            valid_q, last_q;
  logic [NW-1:0]   asg_q, copies_q;
  logic [IW-1:0]   idx_q;
  logic            take;
  logic [CumW-1:0] diff, spoke_num;
  logic [NW-1:0]   total, base, copies;
  logic [31:0]     copies32, idx32;

  assign ready_o = !valid_q || out_ready_i;
  assign take    = ctrl_i.valid && ready_o;

  assign diff      = cum_i - CumW'(off_i);
  assign spoke_num = diff >> shift_i;

  // spokes whose position lies at or below the cumulative weight
  always_comb begin
    if (ctrl_i.last) begin
      total = count_i;
    end else if (cum_i < CumW'(off_i)) begin
      total = '0;
    end else if (spoke_num >= CumW'(count_i)) begin
      total = count_i;
    end else begin
      total = spoke_num[NW-1:0] + NW'(1);
    end
  end

  assign base   = ctrl_i.first ? '0 : asg_q;
  assign copies = (total > base) ? total - base : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      asg_q   <= '0;
    end else begin
      if (take) begin
        valid_q <= 1'b1;
        asg_q   <= ctrl_i.last ? '0 : base + copies;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      copies_q <= copies;
      idx_q    <= idx_i;
      last_q   <= ctrl_i.last;
    end
  end

  assign copies32 = 32'(copies_q);
  assign idx32    = 32'(idx_q);

  assign out_valid_o      = valid_q;
  assign copies_o         = copies32[CopiesW-1:0];
  assign particle_index_o = idx32[IdxW-1:0];
  assign last_o           = last_q;

endmodule

// File: src/systematic_resampler_top_chk.sv
// Port-level checker for systematic_resampler_top, attached by bind.
// Depends on srs_pkg and systematic_resampler_top_assert.svh.
`include "systematic_resampler_top_assert.svh"

module systematic_resampler_top_chk import srs_pkg::*; #(
  parameter int unsigned MAX_COUNT_LOG2 = 8
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               cfg_we_i,
  input logic [CfgW-1:0]    cfg_wdata_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic [CopiesW-1:0] copies_o,
  input logic [IdxW-1:0]    particle_index_o,
  input logic               last_o
);

  localparam int unsigned IW = MAX_COUNT_LOG2;

  logic [CfgW-1:0]    cfg_q;
  logic [IW-1:0]      exp_idx_q;
  logic [CopiesW-1:0] sum_q;
  logic [31:0]        lg, n32, idx32;
  logic               xfer;

  assign xfer = out_valid_o && out_ready_i;

  always_comb begin
    if (cfg_q == '0) begin
      lg = 32'd1;
    end else if (32'(cfg_q) > MAX_COUNT_LOG2) begin
      lg = MAX_COUNT_LOG2;
    end else begin
      lg = 32'(cfg_q);
    end
  end

  assign n32   = 32'd1 << lg;
  assign idx32 = 32'(exp_idx_q);

  // mirror of the set position and of the copies handed out so far
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q     <= CfgW'(CfgReset);
      exp_idx_q <= '0;
      sum_q     <= '0;
    end else if (cfg_we_i) begin
      cfg_q     <= cfg_wdata_i;
      exp_idx_q <= '0;
      sum_q     <= '0;
    end else if (xfer) begin
      exp_idx_q <= last_o ? '0 : exp_idx_q + IW'(1);
      sum_q     <= last_o ? '0 : sum_q + copies_o;
    end
  end

  `SRS_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i,
                   out_valid_o && $stable(copies_o) && $stable(particle_index_o) &&
                   $stable(last_o))
  `SRS_ASSERT_NOW(a_index_seq, xfer, particle_index_o == idx32[IdxW-1:0])
  `SRS_ASSERT_NOW(a_last_pos, xfer, last_o == (idx32 == n32 - 32'd1))
  `SRS_ASSERT_NOW(a_spokes_total, xfer && last_o,
                  CopiesW'(sum_q + copies_o) == n32[CopiesW-1:0])

endmodule

bind systematic_resampler_top systematic_resampler_top_chk #(
  .MAX_COUNT_LOG2(MAX_COUNT_LOG2)
) u_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .cfg_we_i        (cfg_we_i),
  .cfg_wdata_i     (cfg_wdata_i),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .copies_o        (copies_o),
  .particle_index_o(particle_index_o),
  .last_o          (last_o)
);

// File: verif/tb_top.sv
// Self-checking testbench for systematic_resampler_top: directed table, then random sets.
// Copy counts are predicted in-bench from the spoke arithmetic, except on typed rows; depends on srs_pkg.
module tb_top;
  import srs_pkg::*;

  localparam int unsigned MaxLog2    = 8;
  localparam int unsigned FracBits   = 24;
  localparam int unsigned NumItems   = 1800;
  localparam int unsigned StallLimit = 2000;
  localparam int unsigned NumDir     = 25;

  typedef struct packed {
    logic [CopiesW-1:0] copies;
    logic [IdxW-1:0]    pos;
    logic               last;
  } pick_t;

  typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_e;

  typedef struct packed {
    row_kind_e          kind;
    logic [CfgW-1:0]    size_log2;
    logic [WeightW-1:0] weight;
    logic [OffsetW-1:0] offset;
    logic               typed;
    pick_t              pick;
  } dir_row_t;

  typedef enum int {RX_OPEN, RX_BUSY, RX_SPARSE, RX_PERIODIC} rx_mode_e;
  typedef enum int {
    SHAPE_EVEN, SHAPE_RANDOM, SHAPE_SPARSE, SHAPE_SPIKE, SHAPE_SHORT, SHAPE_HEAVY, SHAPE_NOISE
  } shape_e;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [CfgW-1:0]    cfg_wdata_i;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [WeightW-1:0] weight_i;
  logic [OffsetW-1:0] offset_i;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [CopiesW-1:0] copies_o;
  logic [IdxW-1:0]    particle_index_o;
  logic               last_o;

  systematic_resampler_top #(
    .MAX_COUNT_LOG2(MaxLog2),
    .FRACTION_BITS (FracBits)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .weight_i        (weight_i),
    .offset_i        (offset_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .copies_o        (copies_o),
    .particle_index_o(particle_index_o),
    .last_o          (last_o)
  );

  // Directed stimulus; typed rows carry a hand-computed expectation.
  dir_row_t dir_rows [NumDir] = '{
    '{ROW_ITEM, 4'd0,  25'h1000000, 23'h000000, 1'b1, '{9'd256, 8'd0, 1'b0}},
    '{ROW_CFG,  4'd1,  25'h0,       23'h0,      1'b0, '0},
    '{ROW_ITEM, 4'd0,  25'h1000000, 23'h000000, 1'b1, '{9'd2, 8'd0, 1'b0}},
    '{ROW_ITEM, 4'd0,  25'h0000000, 23'h000000, 1'b1, '{9'd0, 8'd1, 1'b1}},
    '{ROW_ITEM, 4'd0,  25'h0000000, 23'h7FFFFF, 1'b1, '{9'd0, 8'd0, 1'b0}},
    '{ROW_ITEM, 4'd0,  25'h1FFFFFF, 23'h000000, 1'b1, '{9'd2, 8'd1, 1'b1}},
    '{ROW_CFG,  4'd0,  25'h0,       23'h0,      1'b0, '0},
    '{ROW_ITEM, 4'd0,  25'h1FFFFFF, 23'h7FFFFF, 1'b1, '{9'd2, 8'd0, 1'b0}},
    '{ROW_ITEM, 4'd0,  25'h0000000, 23'h000000, 1'b1, '{9'd0, 8'd1, 1'b1}},
    '{ROW_CFG,  4'd2,  25'h0,       23'h0,      1'b0, '0},
    '{ROW_ITEM, 4'd0,  25'h0400000, 23'h000000, 1'b0, '0},
    '{ROW_ITEM, 4'd0,  25'h0400000, 23'h155555, 1'b0, '0},
    '{ROW_ITEM, 4'd0,  25'h0400000, 23'h2AAAAA, 1'b0, '0},
    '{ROW_CFG,  4'd15, 25'h0,       23'h0,      1'b0, '0},
    '{ROW_ITEM, 4'd0,  25'h0000000, 23'h7FFFFF, 1'b1, '{9'd0, 8'd0, 1'b0}},
    '{ROW_ITEM, 4'd0,  25'h1FFFFFF, 23'h000000, 1'b0, '0},
    '{ROW_CFG,  4'd3,  25'h0,       23'h0,      1'b0, '0},
    '{ROW_ITEM, 4'd0,  25'h0200000, 23'h000000, 1'b0, '0},
    '{ROW_ITEM, 4'd0,  25'h0200000, 23'h7FFFFF, 1'b0, '0},
    '{ROW_ITEM, 4'd0,  25'h0200000, 23'h000000, 1'b0, '0},
    '{ROW_ITEM, 4'd0,  25'h0200000, 23'h000000, 1'b0, '0},
    '{ROW_ITEM, 4'd0,  25'h0000000, 23'h000000, 1'b0, '0},
    '{ROW_ITEM, 4'd0,  25'h0000000, 23'h000000, 1'b0, '0},
    '{ROW_ITEM, 4'd0,  25'h0600000, 23'h000000, 1'b0, '0},
    '{ROW_ITEM, 4'd0,  25'h0000000, 23'h000000, 1'b0, '0}
  };

  // Predictor state
  logic [CfgW-1:0]    size_log2_q;
  logic [CumW-1:0]    cum_weight;
  logic [CopiesW-1:0] spokes_given;
  logic [IdxW-1:0]    set_pos;
  logic [OffsetW-1:0] first_spoke;
  pick_t              picks_due [$];

  int unsigned n_errors = 0;
  int unsigned n_sent = 0;
  int unsigned burst_left = 0;
  int unsigned idle_cycles = 0;

  rx_mode_e    rx_mode = RX_OPEN;
  int unsigned rx_hold = 0;
  int unsigned rx_tick = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned set_log2(input logic [CfgW-1:0] v);
    if (v < 1) return 1;
    if (v > MaxLog2) return MaxLog2;
    return int'(v);
  endfunction

  task automatic restart_prediction();
    cum_weight   = '0;
    spokes_given = '0;
    set_pos      = '0;
    first_spoke  = '0;
  endtask

  // Copies for one particle: spokes up to the running weight, minus those already handed out.
  function automatic pick_t predict_pick(input logic [WeightW-1:0] w,
                                         input logic [OffsetW-1:0] off);
    int unsigned lg;
    int unsigned sh;
    logic [63:0] n;
    logic [63:0] sum;
    logic [63:0] total;
    logic [63:0] q;
    pick_t p;
    lg = set_log2(size_log2_q);
    sh = (lg >= FracBits) ? 0 : FracBits - lg;
    n = 64'd1 << lg;
    if (set_pos == '0) begin
      cum_weight   = '0;
      spokes_given = '0;
      first_spoke  = off & OffsetW'((64'd1 << sh) - 64'd1);
    end
    sum = 64'(cum_weight) + 64'(w);
    cum_weight = (sum > 64'(CumMax)) ? CumMax : sum[CumW-1:0];
    p.pos  = set_pos;
    p.last = (64'(set_pos) + 64'd1 >= n);
    if (p.last) begin
      total = n;
    end else if (64'(cum_weight) < 64'(first_spoke)) begin
      total = '0;
    end else begin
      q = (64'(cum_weight) - 64'(first_spoke)) >> sh;
      total = (q >= n) ? n : q + 64'd1;
    end
    p.copies = (total > 64'(spokes_given)) ? CopiesW'(total - 64'(spokes_given)) : '0;
    spokes_given = spokes_given + p.copies;
    if (p.last) begin
      set_pos      = '0;
      cum_weight   = '0;
      spokes_given = '0;
    end else begin
      set_pos = set_pos + 1'b1;
    end
    return p;
  endfunction

  task automatic report(input string msg);
    $display("mismatch: %s", msg);
    n_errors++;
  endtask

  // Called right after a rising edge; returns right after the edge of the transfer
  // (or after the gap that follows it).
  task automatic send_item(input logic [WeightW-1:0] w, input logic [OffsetW-1:0] off,
                           input logic typed, input pick_t pick);
    pick_t predicted;
    int unsigned gap;
    in_valid_i <= 1'b1;
    weight_i   <= w;
    offset_i   <= off;
    do @(negedge clk_i); while (!in_ready_o);
    @(posedge clk_i);
    predicted = predict_pick(w, off);
    picks_due.push_back(typed ? pick : predicted);
    n_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 24) : $urandom_range(1, 4);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                : $urandom_range(0, 16);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Register writes only go in once all results are back.
  task automatic write_size_log2(input logic [CfgW-1:0] v);
    in_valid_i <= 1'b0;
    while (picks_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    size_log2_q = v;
    restart_prediction();
  endtask

  // Receiver stall pattern, switching to a randomly chosen mode whenever its hold count runs out
  always @(posedge clk_i) begin
    rx_tick++;
    if (rx_hold == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 3));
      rx_hold = $urandom_range(32, 256);
    end else begin
      rx_hold--;
    end
    case (rx_mode)
      RX_OPEN:   out_ready_i <= 1'b1;
      RX_BUSY:   out_ready_i <= ($urandom_range(0, 3) != 0);
      RX_SPARSE: out_ready_i <= ($urandom_range(0, 3) == 0);
      default:   out_ready_i <= ((rx_tick % 7) < 3);
    endcase
  end

  // Outputs are stable by the falling edge; a transfer seen here lands on the next rising edge.
  always @(negedge clk_i) begin : check_results
    pick_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (picks_due.size() == 0) begin
        report($sformatf("result with nothing pending: copies %0d index %0d last %0d",
                         copies_o, particle_index_o, last_o));
      end else begin
        want = picks_due.pop_front();
        if (copies_o !== want.copies)
          report($sformatf("copies %0d, expected %0d (index %0d)",
                           copies_o, want.copies, want.pos));
        if (particle_index_o !== want.pos)
          report($sformatf("particle_index %0d, expected %0d", particle_index_o, want.pos));
        if (last_o !== want.last)
          report($sformatf("last %0d, expected %0d (index %0d)", last_o, want.last, want.pos));
      end
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= StallLimit) begin
        $display("systematic_resampler_top regression: fail");
        $finish;
      end
    end
  end

  initial begin
    int unsigned phase;
    int unsigned n_set;
    int unsigned n_runs;
    int unsigned run_len;
    int unsigned spike_at;
    bit partial;
    shape_e shape;
    logic [CfgW-1:0] sz;
    longint unsigned raw [256];
    longint unsigned raw_sum;
    logic [63:0] scaled;

    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    weight_i    = '0;
    offset_i    = '0;
    size_log2_q = CfgW'(CfgReset);
    restart_prediction();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        write_size_log2(dir_rows[i].size_log2);
      end else begin
        send_item(dir_rows[i].weight, dir_rows[i].offset, dir_rows[i].typed, dir_rows[i].pick);
      end
    end

    phase = 0;
    while (n_sent < NumItems) begin
      case (phase)
        0:       sz = 4'd1;
        1:       sz = 4'd8;
        2:       sz = 4'd0;
        3:       sz = 4'd15;
        default: sz = ($urandom_range(0, 11) != 0) ? CfgW'($urandom_range(0, 5))
                                                     : CfgW'($urandom_range(6, 15));
      endcase
      write_size_log2(sz);
      n_set   = 1 << set_log2(sz);
      n_runs  = (n_set >= 64) ? 1 : $urandom_range(1, 4);
      // a trailing partial set gets cut short by the next register write
      partial = ($urandom_range(0, 2) == 0);
      for (int r = 0; r < n_runs + partial; r++) begin
        run_len  = (r == n_runs) ? $urandom_range(1, n_set - 1) : n_set;
        shape    = shape_e'($urandom_range(0, 6));
        spike_at = $urandom_range(0, n_set - 1);
        raw_sum  = 0;
        for (int i = 0; i < n_set; i++) begin
          case (shape)
            SHAPE_EVEN:   raw[i] = 1;
            SHAPE_SPARSE: raw[i] = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 1024) : 0;
            SHAPE_SPIKE:  raw[i] = (i == spike_at) ? 1 : 0;
            default:      raw[i] = $urandom_range(1, 1024);
          endcase
          raw_sum += raw[i];
        end
        if (raw_sum == 0) begin
          raw[0]  = 1;
          raw_sum = 1;
        end
        for (int i = 0; i < run_len; i++) begin
          scaled = (64'(raw[i]) << FracBits) / raw_sum;
          case (shape)
            SHAPE_SHORT: scaled = scaled >> $urandom_range(1, 4);
            SHAPE_HEAVY: scaled = scaled + (scaled >> 1);
            SHAPE_NOISE: scaled = 64'($urandom());
            default: ;
          endcase
          send_item(scaled[WeightW-1:0], OffsetW'($urandom_range(0, (1 << OffsetW) - 1)),
                    1'b0, '0);
        end
      end
      phase++;
    end

    in_valid_i <= 1'b0;
    while (picks_due.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("systematic_resampler_top regression: pass");
    end else begin
      $display("systematic_resampler_top regression: fail");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+src
src/srs_pkg.sv
src/srs_accum.sv
src/srs_spoke.sv
src/systematic_resampler_top.sv
src/systematic_resampler_top_chk.sv
verif/tb_top.sv
